// ----- rtl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_dp and lru_key_value_cache_top; no dependencies.
package lkvc_pkg;

    localparam int ENTRIES   = 16;
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int OCC_W     = $clog2(ENTRIES + 1);
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;
    localparam int DATA_W    = 32;
    localparam int IN_W      = 2 * DATA_W;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } lkvc_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } lkvc_cmd_t;

    typedef struct packed {
        logic op_get;
        logic out_full;
    } lkvc_stat_t;

endpackage

// ----- rtl/lru_key_value_cache_top.sv -----
// Top level of the LRU key-value cache.
// Instantiates lkvc_ctrl and lkvc_dp; depends on lkvc_pkg.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready. s_tuser is the operation (0 get,
//   1 put); s_tdata carries the key in bits 31:0 and the put value in 63:32.
//   Each get yields one item on m_tvalid/m_tready: m_tdata is the value found
//   (all ones on a miss), m_tuser is the hit flag. A put yields nothing.
//   Capacity (1..16 entries, 0 acts as 1, above 16 acts as 16) is written
//   through cfg_we/cfg_wdata while no item is in flight.
// Timing:
//   The accept edge registers the parallel key match over all 16 entries;
//   the commit edge commits the entry and recency update and loads the
//   output register, where a get result then shows on m_tvalid. s_tready
//   stays low until the commit, so no new item is accepted before it.
// Reset and stall:
//   Reset empties the store and sets capacity to 16. A get that finds the
//   output register still full waits in its commit cycle, with s_tready low,
//   until m_tready frees it; puts commit regardless of m_tready.
module lru_key_value_cache_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lkvc_pkg::IN_W-1:0]    s_tdata,   // lookup_key, write_value
    input  logic                         s_tuser,   // func
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lkvc_pkg::DATA_W-1:0]  m_tdata,   // read_value
    output logic                         m_tuser    // hit
);
    import lkvc_pkg::*;

    lkvc_cmd_t  cmd;
    lkvc_stat_t stat;

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lkvc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- rtl/lkvc_ctrl.sv -----
// Request sequencer for the LRU key-value cache: accept, then commit.
// Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lkvc_pkg::lkvc_stat_t   stat,
    output lkvc_pkg::lkvc_cmd_t    cmd
);
    import lkvc_pkg::*;

    lkvc_state_t state_reg;
    lkvc_state_t state_next;
    logic        commit_ok;

    assign commit_ok = !(stat.op_get && stat.out_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (commit_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_UPDATE: begin
                cmd.commit = commit_ok;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/lkvc_dp.sv -----
// Datapath of the LRU key-value cache: entry registers, parallel key match,
// recency ranks, occupancy, capacity register and output register. Depends on lkvc_pkg.
module lkvc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic [lkvc_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [lkvc_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tuser,
    input  lkvc_pkg::lkvc_cmd_t           cmd,
    output lkvc_pkg::lkvc_stat_t          stat
);
    import lkvc_pkg::*;

    // entry storage
    logic [DATA_W-1:0] key_mem_reg [ENTRIES];
    logic [DATA_W-1:0] val_mem_reg [ENTRIES];
    logic [SLOT_W-1:0] rank_reg    [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [CAP_W-1:0]  cap_reg;

    // captured item
    logic              func_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [OCC_W-1:0]  thr_reg;
    logic              insert_reg;

    // output register
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    // lookup
    logic [DATA_W-1:0] s_key;
    logic [DATA_W-1:0] s_val;
    logic [ENTRIES-1:0] match_w;
    logic              hit_w;
    logic [SLOT_W-1:0] hit_idx_w;
    logic [SLOT_W-1:0] free_idx_w;
    logic [SLOT_W-1:0] victim_idx_w;
    logic [OCC_W-1:0]  eff_cap_w;
    logic              evict_w;
    logic [SLOT_W-1:0] slot_w;
    logic [OCC_W-1:0]  thr_w;
    logic              put_c;
    logic              touch_c;

    assign s_key = s_tdata[DATA_W-1:0];
    assign s_val = s_tdata[IN_W-1:DATA_W];

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap_w = OCC_W'(1);
        end else if (cap_reg > CAP_W'(ENTRIES)) begin
            eff_cap_w = OCC_W'(ENTRIES);
        end else begin
            eff_cap_w = OCC_W'(cap_reg);
        end
    end

    always_comb begin
        hit_idx_w    = '0;
        free_idx_w   = '0;
        victim_idx_w = '0;
        for (int j = ENTRIES - 1; j >= 0; j--) begin
            match_w[j] = valid_reg[j] && (key_mem_reg[j] == s_key);
            if (match_w[j]) hit_idx_w = SLOT_W'(j);
            if (!valid_reg[j]) free_idx_w = SLOT_W'(j);
            if (valid_reg[j] && (OCC_W'(rank_reg[j]) == occ_reg - OCC_W'(1)))
                victim_idx_w = SLOT_W'(j);
        end
    end

    assign hit_w   = |match_w;
    assign evict_w = (occ_reg != '0) && (occ_reg >= eff_cap_w);

    always_comb begin
        if (hit_w) begin
            slot_w = hit_idx_w;
            thr_w  = OCC_W'(rank_reg[hit_idx_w]);
        end else if (evict_w) begin
            slot_w = victim_idx_w;
            thr_w  = occ_reg - OCC_W'(1);
        end else begin
            slot_w = (occ_reg == '0) ? '0 : free_idx_w;
            thr_w  = occ_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg   <= s_tuser;
            key_reg    <= s_key;
            val_reg    <= s_val;
            hit_reg    <= hit_w;
            slot_reg   <= slot_w;
            thr_reg    <= thr_w;
            insert_reg <= !hit_w && !evict_w;
        end
    end

    assign put_c   = cmd.commit && (func_reg == FUNC_PUT);
    assign touch_c = cmd.commit && ((func_reg == FUNC_PUT) || hit_reg);

    always_ff @(posedge aclk) begin
        if (put_c) begin
            key_mem_reg[slot_reg] <= key_reg;
            val_mem_reg[slot_reg] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int j = 0; j < ENTRIES; j++) rank_reg[j] <= '0;
        end else begin
            if (touch_c) begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (SLOT_W'(j) == slot_reg) begin
                        rank_reg[j] <= '0;
                    end else if (valid_reg[j] && (OCC_W'(rank_reg[j]) < thr_reg)) begin
                        rank_reg[j] <= rank_reg[j] + SLOT_W'(1);
                    end
                end
            end
            if (put_c && !hit_reg && insert_reg) begin
                valid_reg[slot_reg] <= 1'b1;
                occ_reg             <= occ_reg + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(CAP_RESET);
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit && (func_reg == FUNC_GET)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && (func_reg == FUNC_GET)) begin
            m_tdata_reg <= hit_reg ? val_mem_reg[slot_reg] : MISS_VALUE;
            m_tuser_reg <= hit_reg;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;
    assign stat.op_get   = (func_reg == FUNC_GET);
    assign stat.out_full = m_tvalid_reg && !m_tready;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy above entry count");

    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy out of step with valid bits");

    a_keys_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_w))
        else $error("key matches more than one entry");

    a_get_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (func_reg == FUNC_GET) |=> m_tvalid_reg)
        else $error("get committed without a result");

endmodule

// ----- tb/lkvc_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the LRU key-value cache: keeps its own copy of the store and recency
// order, predicts each get result and compares it with the result channel.
// Depends on lkvc_pkg; instantiated by tb_lru_key_value_cache_top.
module lkvc_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [lkvc_pkg::IN_W-1:0]    s_tdata,
    input  logic                         s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [lkvc_pkg::DATA_W-1:0]  m_tdata,
    input  logic                         m_tuser,
    output int                           error_count,
    output int                           pending_results,
    output int                           lookups_checked,
    output int                           hits_seen
);
    import lkvc_pkg::*;

    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              hit;
    } lookup_t;

    logic [DATA_W-1:0] slot_key   [ENTRIES];
    logic [DATA_W-1:0] slot_value [ENTRIES];
    bit                slot_used  [ENTRIES];
    int                slot_age   [ENTRIES];
    int                used_count = 0;
    logic [CAP_W-1:0]  capacity   = CAP_W'(CAP_RESET);
    lookup_t           exp_fifo   [EXP_DEPTH];
    int                exp_rd     = 0;
    int                exp_count  = 0;
    int                errs   = 0;
    int                checked = 0;
    int                hits   = 0;

    function automatic int cap_limit();
        if (capacity == 0) return 1;
        if (capacity > ENTRIES) return ENTRIES;
        return capacity;
    endfunction

    function automatic void make_newest(input int s);
        int r;
        r = slot_age[s];
        for (int j = 0; j < ENTRIES; j++) begin
            if (j != s && slot_used[j] && slot_age[j] < r) slot_age[j]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic int find_slot(input logic [DATA_W-1:0] key);
        for (int j = 0; j < ENTRIES; j++) begin
            if (slot_used[j] && slot_key[j] == key) return j;
        end
        return -1;
    endfunction

    function automatic lookup_t cache_get(input logic [DATA_W-1:0] key);
        int      s;
        lookup_t res;
        s = find_slot(key);
        if (s >= 0) begin
            make_newest(s);
            res.read_value = slot_value[s];
            res.hit        = 1'b1;
        end else begin
            res.read_value = MISS_VALUE;
            res.hit        = 1'b0;
        end
        return res;
    endfunction

    function automatic void cache_put(input logic [DATA_W-1:0] key,
                                      input logic [DATA_W-1:0] value);
        int s;
        s = find_slot(key);
        if (s >= 0) begin
            slot_value[s] = value;
            make_newest(s);
            return;
        end
        if (used_count > 0 && used_count >= cap_limit()) begin
            // evict the oldest entry in place
            s = 0;
            for (int j = 0; j < ENTRIES; j++) begin
                if (slot_used[j] && slot_age[j] == used_count - 1) begin
                    s = j;
                    break;
                end
            end
            slot_key[s]   = key;
            slot_value[s] = value;
            make_newest(s);
            return;
        end
        s = 0;
        for (int j = 0; j < ENTRIES; j++) begin
            if (!slot_used[j]) begin
                s = j;
                break;
            end
        end
        slot_used[s]  = 1'b1;
        slot_key[s]   = key;
        slot_value[s] = value;
        slot_age[s]   = used_count;
        used_count++;
        make_newest(s);
    endfunction

    function automatic void note_mismatch(input string what);
        if (errs < 10) $display("%0t mismatch: %s", $realtime, what);
        errs++;
    endfunction

    always @(posedge aclk) begin
        lookup_t want;
        lookup_t pred;
        if (!aresetn) begin
            for (int j = 0; j < ENTRIES; j++) begin
                slot_used[j] = 1'b0;
                slot_age[j]  = 0;
            end
            used_count = 0;
            capacity   = CAP_W'(CAP_RESET);
            exp_rd     = 0;
            exp_count  = 0;
        end else begin
            if (cfg_we) capacity = cfg_wdata;
            if (m_tvalid && m_tready) begin
                if (exp_count == 0) begin
                    note_mismatch($sformatf("unexpected item value=%h hit=%b",
                                            m_tdata, m_tuser));
                end else begin
                    want      = exp_fifo[exp_rd];
                    exp_rd    = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    checked++;
                    if (m_tuser === 1'b1) hits++;
                    if (m_tdata !== want.read_value)
                        note_mismatch($sformatf("read_value exp=%h got=%h",
                                                want.read_value, m_tdata));
                    if (m_tuser !== want.hit)
                        note_mismatch($sformatf("hit exp=%b got=%b", want.hit, m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_GET) begin
                    pred = cache_get(s_tdata[DATA_W-1:0]);
                    if (exp_count == EXP_DEPTH) begin
                        note_mismatch("too many lookups without a result");
                    end else begin
                        exp_fifo[(exp_rd + exp_count) % EXP_DEPTH] = pred;
                        exp_count++;
                    end
                end else begin
                    cache_put(s_tdata[DATA_W-1:0], s_tdata[IN_W-1:DATA_W]);
                end
            end
        end
        error_count     <= errs;
        pending_results <= exp_count;
        lookups_checked <= checked;
        hits_seen       <= hits;
    end

endmodule

// ----- tb/tb_lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// Testbench top for lru_key_value_cache_top: directed and random get/put traffic over
// several capacity settings, random stalls on both sides. Depends on lkvc_pkg, lkvc_checker.
module tb_lru_key_value_cache_top;
    import lkvc_pkg::*;

    localparam int PHASE_ITEMS = 150;
    localparam int POOL_MAX    = 24;
    localparam int HOLD_CYCLES = 300;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CAP_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tready  = 1'b0;
    wire               s_tready;
    wire               m_tvalid;
    wire  [DATA_W-1:0] m_tdata;
    wire               m_tuser;

    int                gap_pct      = 0;
    bit                hold_request = 1'b0;
    bit                hold_served  = 1'b0;
    int                hold_left    = 0;
    int                items_sent   = 0;
    int                settings_used = 0;
    logic [CAP_W-1:0]  cap_now      = CAP_W'(CAP_RESET);
    logic [DATA_W-1:0] key_pool [POOL_MAX];
    logic [CAP_W-1:0]  cap_plan [8];

    int error_count;
    int pending_results;
    int lookups_checked;
    int hits_seen;

    always #6 aclk = ~aclk;

    lru_key_value_cache_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lkvc_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .pending_results (pending_results),
        .lookups_checked (lookups_checked),
        .hits_seen       (hits_seen)
    );

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_served) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= gap_pct);
        end
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic offer(input logic func, input logic [DATA_W-1:0] key,
                         input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_now = cap;
        settings_used++;
    endtask

    task automatic run_phase(input bit quiet, input bit squeeze);
        int                eff;
        int                pool_n;
        logic              func;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        eff    = (cap_now == 0) ? 1 : ((cap_now > ENTRIES) ? ENTRIES : cap_now);
        pool_n = (eff + 3 > POOL_MAX) ? POOL_MAX : eff + 3;
        for (int i = 0; i < pool_n; i++)
            key_pool[i] = (i == 0) ? 32'h0 : ((i == 1) ? 32'h8000_0000 : $urandom);
        gap_pct <= quiet ? 0 : 8;
        if (squeeze) hold_request <= 1'b1;
        repeat (PHASE_ITEMS) begin
            func  = 1'($urandom_range(1));
            key   = ($urandom_range(9) != 0) ? key_pool[$urandom_range(pool_n - 1)] : $urandom;
            value = ($urandom_range(15) == 0) ? MISS_VALUE : $urandom;
            offer(func, key, value);
        end
    endtask

    initial begin
        cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4, 5'd17, 5'd2, 5'd9};
        cap_plan[7] = CAP_W'($urandom_range(1, ENTRIES));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        gap_pct <= 8;

        offer(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        offer(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        offer(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        offer(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        offer(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        offer(FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        offer(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        offer(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        offer(FUNC_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
        offer(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        offer(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
        offer(FUNC_GET, 32'hFFFF_FFFE, 32'h0000_0000);
        // shrink below occupancy: a put miss replaces only the oldest entry
        set_capacity(5'd1);
        offer(FUNC_PUT, 32'h0000_0010, 32'h1234_5678);
        offer(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        offer(FUNC_GET, 32'h0000_0010, 32'h0000_0000);
        offer(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        offer(FUNC_PUT, 32'h0000_0020, 32'h0000_0000);
        offer(FUNC_GET, 32'h0000_0010, 32'h0000_0000);

        for (int p = 0; p < 8; p++) begin
            set_capacity(cap_plan[p]);
            run_phase(p == 2, p == 5);
        end
        wait_idle();

        $display("sent %0d items over %0d capacity settings (0, 1..16 and above 16)",
                 items_sent, settings_used);
        $display("checked %0d lookups, %0d of them hits", lookups_checked, hits_seen);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
